FILE: src/ppp_pkg.sv
// shared widths, types, register indexes and reset values for the perspective point projection core
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

	// screen coordinate width
	localparam int COORD_BITS = 16;

	localparam int PT_W      = 16;
	localparam int TRIG_W    = 16;
	localparam int RAD_W     = 15;
	localparam int FRAC_BITS = 15;
	localparam int PROD_FRAC = 30;
	localparam int PROD_W    = 32;
	localparam int XV_W      = 33;
	localparam int WIDE_W    = 48;
	localparam int XMAG_W    = 32;
	localparam int MAG_W     = 47;
	localparam int Y_SPLIT   = 24;
	localparam int PYL_W     = RAD_W + Y_SPLIT;
	localparam int PYH_W     = RAD_W + MAG_W - Y_SPLIT;
	localparam int NUM_MIN_W = 62;
	localparam int DIV_W     = (MAG_W + COORD_BITS > NUM_MIN_W) ?
		MAG_W + COORD_BITS : NUM_MIN_W;

	localparam int IN_DATA_W  = 3 * PT_W;
	localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SIN_THETA       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COS_THETA       = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SIN_PHI         = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COS_PHI         = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_RADIUS     = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_DISTANCE = CFG_IDX_W'(5);

	typedef logic signed [PT_W-1:0]       pt_t;
	typedef logic signed [TRIG_W-1:0]     trig_t;
	typedef logic        [RAD_W-1:0]      ulen_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [XV_W-1:0]       xv_t;
	typedef logic signed [WIDE_W-1:0]     wide_t;
	typedef logic        [XMAG_W-1:0]     xmag_t;
	typedef logic        [MAG_W-1:0]      mag_t;
	typedef logic        [PYL_W-1:0]      pyl_t;
	typedef logic        [PYH_W-1:0]      pyh_t;
	typedef logic        [DIV_W-1:0]      num_t;
	typedef logic        [COORD_BITS-1:0] qmag_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [OUT_DATA_W-1:0] out_data_t;

	typedef struct packed {
		trig_t sin_theta;
		trig_t cos_theta;
		trig_t sin_phi;
		trig_t cos_phi;
		ulen_t view_radius;
		ulen_t screen_distance;
	} ppp_cfg_t;

	typedef struct packed {
		prod_t sp_ct;
		prod_t sp_st;
		prod_t cp_ct;
		prod_t cp_st;
	} ppp_trig_t;

	// control that travels with each beat through the pipe
	typedef struct packed {
		logic valid;
		logic front;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} ppp_ctl_t;

	typedef struct packed {
		logic   in_front;
		coord_t screen_y;
		coord_t screen_x;
	} ppp_res_t;

	localparam ppp_cfg_t CFG_RESET = '{
		sin_theta:       trig_t'(0),
		cos_theta:       trig_t'(32767),
		sin_phi:         trig_t'(0),
		cos_phi:         trig_t'(32767),
		view_radius:     ulen_t'(1000),
		screen_distance: ulen_t'(800)
	};

	localparam ppp_trig_t TRIG_RESET = '{
		sp_ct: prod_t'(CFG_RESET.sin_phi) * prod_t'(CFG_RESET.cos_theta),
		sp_st: prod_t'(CFG_RESET.sin_phi) * prod_t'(CFG_RESET.sin_theta),
		cp_ct: prod_t'(CFG_RESET.cos_phi) * prod_t'(CFG_RESET.cos_theta),
		cp_st: prod_t'(CFG_RESET.cos_phi) * prod_t'(CFG_RESET.sin_theta)
	};

	localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});

endpackage

`default_nettype wire

FILE: src/ppp_cfg.sv
// view registers and the four registered angle products
// depends on ppp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [ppp_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [ppp_pkg::CFG_DATA_W-1:0]    wr_data,
	output ppp_pkg::ppp_cfg_t                 cfg,
	output ppp_pkg::ppp_trig_t                trig
);

	ppp_pkg::ppp_cfg_t  cfg_q;
	ppp_pkg::ppp_trig_t trig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ppp_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (wr_index)
				ppp_pkg::REG_SIN_THETA: begin
					cfg_q.sin_theta <= ppp_pkg::trig_t'(wr_data);
				end
				ppp_pkg::REG_COS_THETA: begin
					cfg_q.cos_theta <= ppp_pkg::trig_t'(wr_data);
				end
				ppp_pkg::REG_SIN_PHI: begin
					cfg_q.sin_phi <= ppp_pkg::trig_t'(wr_data);
				end
				ppp_pkg::REG_COS_PHI: begin
					cfg_q.cos_phi <= ppp_pkg::trig_t'(wr_data);
				end
				ppp_pkg::REG_VIEW_RADIUS: begin
					cfg_q.view_radius <= wr_data[ppp_pkg::RAD_W-1:0];
				end
				ppp_pkg::REG_SCREEN_DISTANCE: begin
					cfg_q.screen_distance <= wr_data[ppp_pkg::RAD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Q2.30 products, registered from the view registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= ppp_pkg::TRIG_RESET;
		end else begin
			trig_q.sp_ct <= ppp_pkg::prod_t'(cfg_q.sin_phi) * ppp_pkg::prod_t'(cfg_q.cos_theta);
			trig_q.sp_st <= ppp_pkg::prod_t'(cfg_q.sin_phi) * ppp_pkg::prod_t'(cfg_q.sin_theta);
			trig_q.cp_ct <= ppp_pkg::prod_t'(cfg_q.cos_phi) * ppp_pkg::prod_t'(cfg_q.cos_theta);
			trig_q.cp_st <= ppp_pkg::prod_t'(cfg_q.cos_phi) * ppp_pkg::prod_t'(cfg_q.sin_theta);
		end
	end

	assign cfg  = cfg_q;
	assign trig = trig_q;

endmodule

`default_nettype wire

FILE: src/ppp_xform.sv
// front end: view rotation, depth test and scaling of the numerators, six stages
// depends on ppp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppp_xform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  ppp_pkg::pt_t       point_x,
	input  ppp_pkg::pt_t       point_y,
	input  ppp_pkg::pt_t       point_z,
	input  ppp_pkg::ppp_cfg_t  cfg,
	input  ppp_pkg::ppp_trig_t trig,
	output ppp_pkg::ppp_ctl_t  ctl,
	output ppp_pkg::num_t      num_x,
	output ppp_pkg::num_t      num_y,
	output ppp_pkg::mag_t      den
);

	logic valid_s1, valid_s2, valid_s3;
	ppp_pkg::ppp_ctl_t ctl_s4, ctl_s5, ctl_s6;

	ppp_pkg::pt_t   x_s1, y_s1, z_s1;
	ppp_pkg::prod_t p_xct_s2, p_zst_s2, p_ysp_s2, p_ycp_s2;
	ppp_pkg::wide_t p_xcpst_s2, p_zcpct_s2, p_xspst_s2, p_zspct_s2;
	ppp_pkg::xv_t   xv_s3;
	ppp_pkg::wide_t yv_s3, zv_s3;
	ppp_pkg::xmag_t xmag_s4;
	ppp_pkg::mag_t  ymag_s4, zv_s4;
	ppp_pkg::mag_t  px_s5, zv_s5;
	ppp_pkg::pyl_t  pyl_s5;
	ppp_pkg::pyh_t  pyh_s5;
	ppp_pkg::num_t  nx_s6, ny_s6;
	ppp_pkg::mag_t  zv_s6;

	ppp_pkg::xv_t   xv_c, xabs_c;
	ppp_pkg::wide_t yv_c, zv_c, yabs_c;
	logic           front_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			ctl_s4   <= '0;
			ctl_s5   <= '0;
			ctl_s6   <= '0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			ctl_s4   <= '{valid: valid_s3, front: front_c,
				neg_x: xv_s3[ppp_pkg::XV_W-1], neg_y: yv_s3[ppp_pkg::WIDE_W-1],
				ovf_x: 1'b0, ovf_y: 1'b0};
			ctl_s5   <= ctl_s4;
			ctl_s6   <= ctl_s5;
		end
	end

	// rotation sums and magnitudes
	always_comb begin
		xv_c = ppp_pkg::xv_t'(p_xct_s2) - ppp_pkg::xv_t'(p_zst_s2);
		yv_c = (ppp_pkg::wide_t'(p_ysp_s2) <<< ppp_pkg::FRAC_BITS) - p_xcpst_s2 - p_zcpct_s2;
		zv_c = (ppp_pkg::wide_t'({1'b0, cfg.view_radius}) <<< ppp_pkg::PROD_FRAC)
			- p_xspst_s2 - (ppp_pkg::wide_t'(p_ycp_s2) <<< ppp_pkg::FRAC_BITS) - p_zspct_s2;
		xabs_c  = xv_s3[ppp_pkg::XV_W-1] ? -xv_s3 : xv_s3;
		yabs_c  = yv_s3[ppp_pkg::WIDE_W-1] ? -yv_s3 : yv_s3;
		front_c = !zv_s3[ppp_pkg::WIDE_W-1] && (zv_s3 != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: input beat
			x_s1 <= point_x;
			y_s1 <= point_y;
			z_s1 <= point_z;
			// s2: coordinate by angle products
			p_xct_s2   <= ppp_pkg::prod_t'(x_s1) * ppp_pkg::prod_t'(cfg.cos_theta);
			p_zst_s2   <= ppp_pkg::prod_t'(z_s1) * ppp_pkg::prod_t'(cfg.sin_theta);
			p_ysp_s2   <= ppp_pkg::prod_t'(y_s1) * ppp_pkg::prod_t'(cfg.sin_phi);
			p_ycp_s2   <= ppp_pkg::prod_t'(y_s1) * ppp_pkg::prod_t'(cfg.cos_phi);
			p_xcpst_s2 <= ppp_pkg::wide_t'(x_s1) * ppp_pkg::wide_t'(trig.cp_st);
			p_zcpct_s2 <= ppp_pkg::wide_t'(z_s1) * ppp_pkg::wide_t'(trig.cp_ct);
			p_xspst_s2 <= ppp_pkg::wide_t'(x_s1) * ppp_pkg::wide_t'(trig.sp_st);
			p_zspct_s2 <= ppp_pkg::wide_t'(z_s1) * ppp_pkg::wide_t'(trig.sp_ct);
			// s3: view coordinates
			xv_s3 <= xv_c;
			yv_s3 <= yv_c;
			zv_s3 <= zv_c;
			// s4: magnitudes, depth as divisor
			xmag_s4 <= xabs_c[ppp_pkg::XMAG_W-1:0];
			ymag_s4 <= yabs_c[ppp_pkg::MAG_W-1:0];
			zv_s4   <= zv_s3[ppp_pkg::MAG_W-1:0];
			// s5: scale by screen distance, y split in two partial products
			px_s5  <= ppp_pkg::mag_t'(cfg.screen_distance) * ppp_pkg::mag_t'(xmag_s4);
			pyl_s5 <= ppp_pkg::pyl_t'(cfg.screen_distance)
				* ppp_pkg::pyl_t'(ymag_s4[ppp_pkg::Y_SPLIT-1:0]);
			pyh_s5 <= ppp_pkg::pyh_t'(cfg.screen_distance)
				* ppp_pkg::pyh_t'(ymag_s4[ppp_pkg::MAG_W-1:ppp_pkg::Y_SPLIT]);
			zv_s5  <= zv_s4;
			// s6: numerators
			nx_s6 <= ppp_pkg::num_t'(px_s5) << ppp_pkg::FRAC_BITS;
			ny_s6 <= (ppp_pkg::num_t'(pyh_s5) << ppp_pkg::Y_SPLIT) + ppp_pkg::num_t'(pyl_s5);
			zv_s6 <= zv_s5;
		end
	end

	assign ctl   = ctl_s6;
	assign num_x = nx_s6;
	assign num_y = ny_s6;
	assign den   = zv_s6;

endmodule

`default_nettype wire

FILE: src/ppp_div.sv
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage
// with range check up front and sign and saturation at the end; depends on ppp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ppp_pkg::ppp_ctl_t ctl_in,
	input  ppp_pkg::num_t     num_x,
	input  ppp_pkg::num_t     num_y,
	input  ppp_pkg::mag_t     den,
	output ppp_pkg::ppp_ctl_t ctl_out,
	output ppp_pkg::coord_t   screen_x,
	output ppp_pkg::coord_t   screen_y
);

	ppp_pkg::ppp_ctl_t ctl_s [0:ppp_pkg::COORD_BITS];
	ppp_pkg::num_t     rx_s  [0:ppp_pkg::COORD_BITS-1];
	ppp_pkg::num_t     ry_s  [0:ppp_pkg::COORD_BITS-1];
	ppp_pkg::mag_t     den_s [0:ppp_pkg::COORD_BITS-1];
	ppp_pkg::qmag_t    qx_s  [0:ppp_pkg::COORD_BITS];
	ppp_pkg::qmag_t    qy_s  [0:ppp_pkg::COORD_BITS];

	ppp_pkg::num_t     lim_c;
	ppp_pkg::ppp_ctl_t ctl0_c;

	// quotient would not fit in COORD_BITS magnitude bits
	always_comb begin
		lim_c        = ppp_pkg::num_t'(den) << ppp_pkg::COORD_BITS;
		ctl0_c       = ctl_in;
		ctl0_c.ovf_x = num_x >= lim_c;
		ctl0_c.ovf_y = num_y >= lim_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl0_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]  <= num_x;
			ry_s[0]  <= num_y;
			den_s[0] <= den;
			qx_s[0]  <= '0;
			qy_s[0]  <= '0;
		end
	end

	for (genvar k = 1; k <= ppp_pkg::COORD_BITS; k++) begin : g_step
		ppp_pkg::num_t  dsh;
		ppp_pkg::qmag_t qxn, qyn;
		logic           hit_x, hit_y;

		always_comb begin
			dsh   = ppp_pkg::num_t'(den_s[k-1]) << (ppp_pkg::COORD_BITS - k);
			hit_x = rx_s[k-1] >= dsh;
			hit_y = ry_s[k-1] >= dsh;
			qxn   = qx_s[k-1];
			qyn   = qy_s[k-1];
			qxn[ppp_pkg::COORD_BITS-k] = hit_x;
			qyn[ppp_pkg::COORD_BITS-k] = hit_y;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qx_s[k] <= qxn;
				qy_s[k] <= qyn;
			end
		end

		// the last stage keeps only the quotient
		if (k < ppp_pkg::COORD_BITS) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rx_s[k]  <= hit_x ? rx_s[k-1] - dsh : rx_s[k-1];
					ry_s[k]  <= hit_y ? ry_s[k-1] - dsh : ry_s[k-1];
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	ppp_pkg::ppp_ctl_t ctl_f;
	ppp_pkg::qmag_t    qx_f, qy_f;

	assign ctl_f = ctl_s[ppp_pkg::COORD_BITS];
	assign qx_f  = qx_s[ppp_pkg::COORD_BITS];
	assign qy_f  = qy_s[ppp_pkg::COORD_BITS];

	// sign and clamp; a top quotient bit already means out of range either way
	always_comb begin
		if (!ctl_f.front) begin
			screen_x = '0;
		end else if (ctl_f.neg_x) begin
			screen_x = (ctl_f.ovf_x || qx_f[ppp_pkg::COORD_BITS-1]) ?
				ppp_pkg::COORD_MIN : ppp_pkg::coord_t'(-qx_f);
		end else begin
			screen_x = (ctl_f.ovf_x || qx_f[ppp_pkg::COORD_BITS-1]) ?
				ppp_pkg::COORD_MAX : ppp_pkg::coord_t'(qx_f);
		end
		if (!ctl_f.front) begin
			screen_y = '0;
		end else if (ctl_f.neg_y) begin
			screen_y = (ctl_f.ovf_y || qy_f[ppp_pkg::COORD_BITS-1]) ?
				ppp_pkg::COORD_MIN : ppp_pkg::coord_t'(-qy_f);
		end else begin
			screen_y = (ctl_f.ovf_y || qy_f[ppp_pkg::COORD_BITS-1]) ?
				ppp_pkg::COORD_MAX : ppp_pkg::coord_t'(qy_f);
		end
	end

	assign ctl_out = ctl_f;

endmodule

`default_nettype wire

FILE: src/ppp_outbuf.sv
// two-entry output buffer that decouples the pipe from the result stream
// depends on ppp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppp_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ppp_pkg::ppp_res_t push_res,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output ppp_pkg::ppp_res_t out_res
);

	ppp_pkg::ppp_res_t slot_q [0:1];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign out_valid = cnt_q != 2'd0;
	assign room      = cnt_q != 2'd2;
	assign pop       = out_valid && out_ready;
	assign out_res   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_res;
		end
	end

endmodule

`default_nettype wire

FILE: src/perspective_point_projection_core.sv
// Perspective point projection core: takes one world vertex per beat on the input stream and
// returns its screen position on the output stream, one result per vertex, in order. A new
// vertex can be taken every clock while the output buffer has room. Between input and output
// lie six front-end stages (input, angle products, rotation, magnitude, distance scaling,
// numerators), one range-check stage and one stage per quotient bit of the divider, and the
// output buffer. The two-entry output buffer takes results while the sink stalls; the whole
// pipe holds only once both entries are full. in_front low means the vertex is at or behind
// the viewpoint and both coordinates read zero. View registers may be written only while no
// vertex is in flight; the configuration port is always ready.
// depends on ppp_pkg, ppp_cfg, ppp_xform, ppp_div, ppp_outbuf
`timescale 1ns / 1ps
`default_nettype none

module perspective_point_projection_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ppp_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // point_x, point_y, point_z
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [ppp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // screen_x, screen_y
	output logic                               m_axis_tuser,  // in_front
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ppp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ppp_pkg::ppp_cfg_t  cfg;
	ppp_pkg::ppp_trig_t trig;
	ppp_pkg::ppp_ctl_t  fe_ctl, div_ctl;
	ppp_pkg::num_t      fe_num_x, fe_num_y;
	ppp_pkg::mag_t      fe_den;
	ppp_pkg::coord_t    div_x, div_y;
	ppp_pkg::ppp_res_t  div_res, ob_res;
	logic               pipe_en;
	logic               push;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = pipe_en;

	ppp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.trig     (trig)
	);

	ppp_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (s_axis_tvalid),
		.point_x  (ppp_pkg::pt_t'(s_axis_tdata[ppp_pkg::PT_W-1:0])),
		.point_y  (ppp_pkg::pt_t'(s_axis_tdata[2*ppp_pkg::PT_W-1:ppp_pkg::PT_W])),
		.point_z  (ppp_pkg::pt_t'(s_axis_tdata[3*ppp_pkg::PT_W-1:2*ppp_pkg::PT_W])),
		.cfg      (cfg),
		.trig     (trig),
		.ctl      (fe_ctl),
		.num_x    (fe_num_x),
		.num_y    (fe_num_y),
		.den      (fe_den)
	);

	ppp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.ctl_in   (fe_ctl),
		.num_x    (fe_num_x),
		.num_y    (fe_num_y),
		.den      (fe_den),
		.ctl_out  (div_ctl),
		.screen_x (div_x),
		.screen_y (div_y)
	);

	assign div_res = '{in_front: div_ctl.front, screen_y: div_y, screen_x: div_x};
	assign push    = pipe_en && div_ctl.valid;

	ppp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (div_res),
		.room      (pipe_en),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (ob_res)
	);

	assign m_axis_tdata = ppp_pkg::out_data_t'({ob_res.screen_y, ob_res.screen_x});
	assign m_axis_tuser = ob_res.in_front;

	// a vertex behind the viewpoint carries zero coordinates
	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("result behind viewpoint with nonzero coordinates");

	// a beat marked in front never reaches the divider with a zero divisor
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		fe_ctl.valid && fe_ctl.front |-> fe_den != '0)
		else $error("zero divisor on a beat in front of the viewpoint");

	// while the pipe is held the divider output does not move
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(div_ctl) && $stable(div_x) && $stable(div_y))
		else $error("divider output changed during a stall");

endmodule

`default_nettype wire

FILE: tb/perspective_point_projection_core_tb.sv
// self-checking testbench for perspective_point_projection_core: streams world vertices,
// predicts each screen position in 64-bit integer math and checks every output beat in order
// depends on ppp_pkg and the core rtl
`timescale 1ns / 1ps

module perspective_point_projection_core_tb;
	import ppp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int BATCH_ITEMS  = 330;
	localparam int MAX_REPORTS  = 40;

	// indexes past the register list, writes there must not land anywhere
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

	typedef enum int {VIEW_ORBIT, VIEW_EDGES, VIEW_NOISE} view_mode_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		logic   front;
	} proj_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // point_x, point_y, point_z
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // screen_x, screen_y
	logic                  m_axis_tuser;        // in_front
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	ppp_cfg_t             view = CFG_RESET;
	logic [IN_DATA_W-1:0] vertex_q[$];
	proj_t                proj_q[$];

	int send_idle_pct = 36;
	int stall_pct     = 69;
	bit send_hold     = 1'b0;
	int hold_reqs     = 0;
	int holds_done    = 0;
	int hold_left     = 0;
	bit vtx_took      = 1'b0;

	int errors    = 0;
	int cycles    = 0;
	int n_checked = 0;
	int n_front   = 0;
	int n_behind  = 0;
	int n_clamped = 0;
	int n_views   = 1;
	int n_pauses  = 0;

	perspective_point_projection_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d results still outstanding", $time, proj_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic coord_t clamp_coord(input longint q);
		if (q > longint'(COORD_MAX)) begin
			n_clamped++;
			return COORD_MAX;
		end
		if (q < longint'(COORD_MIN)) begin
			n_clamped++;
			return COORD_MIN;
		end
		return coord_t'(q);
	endfunction

	// rotate into view space, push the eye back by the radius, divide by depth
	function automatic proj_t project_vertex(input logic [IN_DATA_W-1:0] v);
		longint x, y, z, st, ct, sp, cp, rad, scr_dist, xv, yv, zv;
		proj_t r;
		x        = pt_t'(v[PT_W-1:0]);
		y        = pt_t'(v[2*PT_W-1:PT_W]);
		z        = pt_t'(v[3*PT_W-1:2*PT_W]);
		st       = view.sin_theta;
		ct       = view.cos_theta;
		sp       = view.sin_phi;
		cp       = view.cos_phi;
		rad      = view.view_radius;
		scr_dist = view.screen_distance;
		xv = x * ct - z * st;
		yv = y * sp * 32768 - x * (cp * st) - z * (cp * ct);
		zv = (rad <<< 30) - x * (sp * st) - y * cp * 32768 - z * (sp * ct);
		r = '{sx: '0, sy: '0, front: 1'b0};
		if (zv > 0) begin
			r.sx    = clamp_coord(scr_dist * xv * 32768 / zv);
			r.sy    = clamp_coord(scr_dist * yv / zv);
			r.front = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [IN_DATA_W-1:0] vtx(input int x, input int y, input int z);
		return {pt_t'(z), pt_t'(y), pt_t'(x)};
	endfunction

	// mostly points around the origin at the scale of the orbit, some full range noise
	function automatic pt_t coord_pick(input int span);
		case ($urandom_range(0, 11))
			0, 1: return pt_t'($urandom);
			2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			default: return pt_t'(int'($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	task automatic flag_error(input string what, input logic signed [31:0] want,
			input logic signed [31:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
				$time, what, n_checked, want, got);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SIN_THETA:       view.sin_theta       = trig_t'(val);
			REG_COS_THETA:       view.cos_theta       = trig_t'(val);
			REG_SIN_PHI:         view.sin_phi         = trig_t'(val);
			REG_COS_PHI:         view.cos_phi         = trig_t'(val);
			REG_VIEW_RADIUS:     view.view_radius     = val[RAD_W-1:0];
			REG_SCREEN_DISTANCE: view.screen_distance = val[RAD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_view(input logic [CFG_DATA_W-1:0] st, input logic [CFG_DATA_W-1:0] ct,
			input logic [CFG_DATA_W-1:0] sp, input logic [CFG_DATA_W-1:0] cp,
			input logic [CFG_DATA_W-1:0] rad, input logic [CFG_DATA_W-1:0] scr_dist);
		cfg_write(REG_SIN_THETA, st);
		cfg_write(REG_COS_THETA, ct);
		cfg_write(n_views[0] ? REG_SPARE_B : REG_SPARE_A, CFG_DATA_W'($urandom));
		cfg_write(REG_SIN_PHI, sp);
		cfg_write(REG_COS_PHI, cp);
		cfg_write(REG_VIEW_RADIUS, rad);
		cfg_write(REG_SCREEN_DISTANCE, scr_dist);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_views++;
	endtask

	task automatic load_view(input view_mode_t mode);
		logic [CFG_DATA_W-1:0] v[6];
		logic [CFG_DATA_W-1:0] c, sn;
		case (mode)
			VIEW_ORBIT: begin
				// proper rotations from a few angles, both signs
				for (int a = 0; a < 2; a++) begin
					case ($urandom_range(0, 4))
						0: begin c = 16'd32767; sn = 16'd0;     end
						1: begin c = 16'd28378; sn = 16'd16384; end
						2: begin c = 16'd23170; sn = 16'd23170; end
						3: begin c = 16'd16384; sn = 16'd28378; end
						default: begin c = 16'd0; sn = 16'd32767; end
					endcase
					if ($urandom_range(0, 1)) c = -c;
					if ($urandom_range(0, 1)) sn = -sn;
					v[2*a]   = sn;
					v[2*a+1] = c;
				end
				v[4] = {1'($urandom_range(0, 1)), 15'($urandom_range(2000, 32767))};
				v[5] = {1'($urandom_range(0, 1)), 15'($urandom_range(100, 2000))};
			end
			VIEW_EDGES: begin
				for (int i = 0; i < 6; i++) begin
					case ($urandom_range(0, 4))
						0: v[i] = 16'h8000;
						1: v[i] = 16'h7FFF;
						2: v[i] = 16'h0000;
						3: v[i] = 16'hFFFF;
						default: v[i] = 16'h0001;
					endcase
				end
			end
			default: begin
				for (int i = 0; i < 6; i++) v[i] = CFG_DATA_W'($urandom);
			end
		endcase
		set_view(v[0], v[1], v[2], v[3], v[4], v[5]);
	endtask

	task automatic wait_drained();
		while (vertex_q.size() != 0 || proj_q.size() != 0 || s_axis_tvalid) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_batch(input int count, input bit with_hold, input bit with_pause);
		int span;
		span = view.view_radius / 2 + 1;
		repeat (count) vertex_q.push_back({coord_pick(span), coord_pick(span), coord_pick(span)});
		if (with_hold) hold_reqs++;
		if (with_pause) begin
			while (vertex_q.size() > count / 2) @(posedge clk);
			send_hold = 1'b1;
			while (proj_q.size() != 0 || s_axis_tvalid) @(posedge clk);
			send_hold = 1'b0;
			n_pauses++;
		end
		wait_drained();
	endtask

	// vertex driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !vtx_took) begin
			// beat not taken yet, keep it on the bus
		end else if (vertex_q.size() != 0 && !send_hold &&
				$urandom_range(0, 99) >= send_idle_pct) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= vertex_q[0];
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// result sink, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (holds_done != hold_reqs) begin
			m_axis_tready <= 1'b0;
			holds_done    <= holds_done + 1;
			hold_left     <= HOLD_CYCLES;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// monitor: predict on every accepted vertex, check every accepted result
	always @(posedge clk) begin
		proj_t  want;
		coord_t got_x, got_y;
		if (arst_n) begin
			vtx_took <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				proj_q.push_back(project_vertex(s_axis_tdata));
				void'(vertex_q.pop_front());
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_x = m_axis_tdata[COORD_BITS-1:0];
				got_y = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
				if (proj_q.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected: got x %0d y %0d front %b",
						$time, got_x, got_y, m_axis_tuser);
				end else begin
					want = proj_q.pop_front();
					if (got_x !== want.sx) flag_error("screen_x", want.sx, got_x);
					if (got_y !== want.sy) flag_error("screen_y", want.sy, got_y);
					if (m_axis_tuser !== want.front)
						flag_error("in_front", 32'(want.front), 32'(m_axis_tuser));
					if (want.front) n_front++;
					else n_behind++;
				end
				n_checked++;
			end
		end
	end

	initial begin
		view_mode_t mode;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset view: origin, extremes, behind the eye, clamping both ways on both axes
		vertex_q.push_back(vtx(0, 0, 0));
		vertex_q.push_back(vtx(32767, 32767, 32767));
		vertex_q.push_back(vtx(-32768, -32768, -32768));
		vertex_q.push_back(vtx(32767, 1000, 0));
		vertex_q.push_back(vtx(-32768, 1000, 0));
		vertex_q.push_back(vtx(0, 1000, 32767));
		vertex_q.push_back(vtx(0, 1000, -32768));
		vertex_q.push_back(vtx(123, -456, 789));
		wait_drained();

		// cos_phi of -1 makes depth (y + R): y = -R sits exactly on the eye plane;
		// the radius goes in with the unused top bit set
		set_view(16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h83E8, 16'd800);
		vertex_q.push_back(vtx(100, -1000, 50));
		vertex_q.push_back(vtx(100, -1001, 50));
		vertex_q.push_back(vtx(32767, -999, 0));
		vertex_q.push_back(vtx(-5, -999, 3));
		vertex_q.push_back(vtx(-32768, 32767, -32768));
		wait_drained();

		// all trig at -1, screen distance zero, so every visible point lands on the origin
		set_view(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
		vertex_q.push_back(vtx(1000, 0, -2000));
		vertex_q.push_back(vtx(-32768, 32767, 32767));
		vertex_q.push_back(vtx(7, -7, 7));
		wait_drained();

		for (int s = 0; s < 6; s++) begin
			if (s == 2) begin
				send_idle_pct = 69;
				stall_pct     = 36;
			end
			if (s == 4) begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			case (s)
				1, 5: mode = VIEW_EDGES;
				3: mode = VIEW_NOISE;
				default: mode = VIEW_ORBIT;
			endcase
			load_view(mode);
			run_batch(BATCH_ITEMS, s % 2 == 0, s % 2 == 1);
		end

		$display("checked %0d projected vertices over %0d view settings: %0d in front, %0d behind,",
			n_checked, n_views, n_front, n_behind);
		$display("%0d clamped coordinates, %0d sink hold-offs and %0d source pauses",
			n_clamped, holds_done, n_pauses);
		if (errors == 0 && proj_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: perspective_point_projection_core.f
src/ppp_pkg.sv
src/ppp_cfg.sv
src/ppp_xform.sv
src/ppp_div.sv
src/ppp_outbuf.sv
src/perspective_point_projection_core.sv
tb/perspective_point_projection_core_tb.sv
